[sv/command_frame_parser_assert.svh]
// Assertion macros for the command frame parser port-level checker.
`ifndef COMMAND_FRAME_PARSER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_ASSERT_SVH

// Clocked property, switched off while reset is asserted.
`define CFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen.
`define CFP_NEVER(lbl, cond, msg) `CFP_ASSERT(lbl, !(cond), msg)

`endif

[sv/cfp_pkg.sv]
// Types and constants shared by the command frame parser modules.
package cfp_pkg;

	localparam int FRAME_DEPTH = 8;
	localparam int POS_W       = 4;
	localparam int CMP_W       = 6;
	localparam int CFG_W       = 15;
	localparam int CFG_IDX_W   = 1;

	localparam logic [7:0]  TYPE_TORQUE      = 8'h20;
	localparam logic [7:0]  TYPE_CONTROL     = 8'h30;
	localparam logic [7:0]  CMD_STARTUP      = 8'h01;
	localparam logic [POS_W-1:0] LEN_TORQUE  = 4'd8;
	localparam logic [POS_W-1:0] LEN_CONTROL = 4'd7;

	localparam logic [7:0]  START_MARKER_RST = 8'hAB;
	localparam logic [14:0] TORQUE_LIMIT_RST = 15'd1000;
	localparam logic [7:0]  GAIN_RST         = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MARKER = 1'b0,
		CFG_TORQUE_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_TORQUE  = 2'd0,
		ST_STARTUP = 2'd1,
		ST_OTHER   = 2'd2,
		ST_BADSUM  = 2'd3
	} status_t;

	// Classified frame handed from the front end to the back end.
	typedef struct packed {
		status_t     kind;
		logic [15:0] data;
		logic [7:0]  gain;
	} cmd_t;

	// One result word.
	typedef struct packed {
		status_t            status;
		logic signed [15:0] torque;
		logic [7:0]         gain;
		logic [15:0]        flags;
		logic               seen;
	} result_t;

	// Command queue side band toward the back end.
	typedef struct packed {
		logic avail;
	} cmd_hs_t;

endpackage

[sv/cfp_front.sv]
// Front end: frame hunt, byte counting, running XOR and frame classification.
module cfp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         start_marker,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output logic               cmd_valid,
	output cfp_pkg::cmd_t      cmd
);

	logic [cfp_pkg::POS_W-1:0] pos_q;
	logic [cfp_pkg::POS_W-1:0] len_q;
	logic [7:0]                xor_q;
	logic                      torque_q;
	logic [7:0]                b3_q, b4_q, b5_q;

	logic [cfp_pkg::POS_W-1:0] pos_inc;
	logic                      in_body;
	logic                      is_data;
	logic                      is_last;

	assign pos_inc = pos_q + cfp_pkg::POS_W'(1);
	assign in_body = (pos_q != cfp_pkg::POS_W'(0)) && (pos_q != cfp_pkg::POS_W'(1));
	assign is_data = in_body && (pos_inc < len_q) &&
		(cfp_pkg::CMP_W'(pos_inc) < cfp_pkg::CMP_W'(cfp_pkg::FRAME_DEPTH));
	assign is_last = in_body && !is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			xor_q    <= '0;
			torque_q <= 1'b0;
		end else if (accept) begin
			if (pos_q == cfp_pkg::POS_W'(0)) begin
				if (rx_byte == start_marker) begin
					xor_q <= rx_byte;
					len_q <= '0;
					pos_q <= cfp_pkg::POS_W'(1);
				end
			end else if (pos_q == cfp_pkg::POS_W'(1)) begin
				if (rx_byte == cfp_pkg::TYPE_TORQUE || rx_byte == cfp_pkg::TYPE_CONTROL) begin
					len_q    <= (rx_byte == cfp_pkg::TYPE_TORQUE) ? cfp_pkg::LEN_TORQUE
						: cfp_pkg::LEN_CONTROL;
					torque_q <= (rx_byte == cfp_pkg::TYPE_TORQUE);
					xor_q    <= xor_q ^ rx_byte;
					pos_q    <= cfp_pkg::POS_W'(2);
				end else begin
					pos_q <= '0;
					len_q <= '0;
					xor_q <= '0;
				end
			end else if (is_data) begin
				xor_q <= xor_q ^ rx_byte;
				pos_q <= pos_inc;
			end else begin
				pos_q <= '0;
				len_q <= '0;
				xor_q <= '0;
			end
		end
	end

	// payload bytes that the back end needs
	always_ff @(posedge clk) begin
		if (accept && is_data) begin
			if (pos_q == cfp_pkg::POS_W'(3)) b3_q <= rx_byte;
			if (pos_q == cfp_pkg::POS_W'(4)) b4_q <= rx_byte;
			if (pos_q == cfp_pkg::POS_W'(5)) b5_q <= rx_byte;
		end
	end

	always_comb begin
		cmd_valid = accept && is_last;
		if (rx_byte != xor_q) begin
			cmd.kind = cfp_pkg::ST_BADSUM;
		end else if (torque_q) begin
			cmd.kind = cfp_pkg::ST_TORQUE;
		end else if (b3_q == cfp_pkg::CMD_STARTUP) begin
			cmd.kind = cfp_pkg::ST_STARTUP;
		end else begin
			cmd.kind = cfp_pkg::ST_OTHER;
		end
		cmd.data = torque_q ? {b4_q, b3_q} : {b5_q, b4_q};
		cmd.gain = b5_q;
	end

endmodule

[sv/cfp_cmd_q.sv]
// Two-word queue of classified frames between front end and back end.
module cfp_cmd_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  cfp_pkg::cmd_t     wr_data,
	output logic              full,
	output cfp_pkg::cmd_hs_t  hs_out,
	input  logic              rd_take,
	output cfp_pkg::cmd_t     rd_data
);

	cfp_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_rd;

	assign full         = (cnt_q == 2'd2);
	assign hs_out.avail = (cnt_q != 2'd0);
	assign do_rd        = rd_take && (cnt_q != 2'd0);
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[sv/cfp_back.sv]
// Back end: applies frames to the settings and queues the result words.
module cfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [14:0]          torque_limit,
	input  logic                 cmd_avail,
	input  cfp_pkg::cmd_t        cmd,
	output logic                 cmd_take,
	input  logic                 pop,
	output logic                 empty,
	output cfp_pkg::result_t     result
);

	logic signed [15:0] torque_q;
	logic [7:0]         gain_q;
	logic [15:0]        flags_q;
	logic               seen_q;

	cfp_pkg::result_t res_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	logic signed [16:0] t_s, lim_s, nlim_s, clamp_s;
	cfp_pkg::result_t   nxt;
	logic               do_pop;

	assign cmd_take = cmd_avail && (cnt_q != 2'd2);
	assign do_pop   = pop && (cnt_q != 2'd0);
	assign empty    = (cnt_q == 2'd0);
	assign result   = res_q[rd_ptr_q];

	always_comb begin
		t_s    = signed'({cmd.data[15], cmd.data});
		lim_s  = signed'({2'b00, torque_limit});
		nlim_s = -lim_s;
		if (t_s > lim_s) begin
			clamp_s = lim_s;
		end else if (t_s < nlim_s) begin
			clamp_s = nlim_s;
		end else begin
			clamp_s = t_s;
		end
		nxt.status = cmd.kind;
		nxt.torque = torque_q;
		nxt.gain   = gain_q;
		nxt.flags  = flags_q;
		nxt.seen   = seen_q;
		case (cmd.kind)
			cfp_pkg::ST_TORQUE: begin
				nxt.torque = 16'(clamp_s);
				nxt.gain   = cmd.gain;
			end
			cfp_pkg::ST_STARTUP: begin
				nxt.flags = cmd.data;
				nxt.seen  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_q <= '0;
			gain_q   <= cfp_pkg::GAIN_RST;
			flags_q  <= '0;
			seen_q   <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd_take) begin
				torque_q <= nxt.torque;
				gain_q   <= nxt.gain;
				flags_q  <= nxt.flags;
				seen_q   <= nxt.seen;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, cmd_take} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) res_q[wr_ptr_q] <= nxt;
	end

endmodule

[sv/command_frame_parser.sv]
// Top level of the command frame parser: config registers and front/back wiring.
//
//  channel   direction  handshake              word
//  -------   ---------  ---------------------  ------------------------------------
//  input     in         push / full            rx_byte
//  result    out        empty / pop            frame_status, torque, gain, flags, seen
//  config    in         cfg_write (no wait)    cfg_index, cfg_data
//
// One byte per cycle is taken while full is low. The edge that takes a check
// byte writes the command queue; the back end moves the word into its
// two-word result queue once that queue has room, and the word is on the
// ports once it heads the result queue. full rises only when the command
// queue holds two frames, i.e. when results are not popped. Reset is
// asynchronous, needs no clearing pass, restores defaults and resumes hunting.
module command_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      rx_byte,
	input  logic                            pop,
	output logic                            empty,
	output logic [1:0]                      frame_status,
	output logic signed [15:0]              torque_setting_out,
	output logic [7:0]                      gain_setting_out,
	output logic [15:0]                     startup_flags_out,
	output logic                            startup_seen_out,
	input  logic                            cfg_write,
	input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfp_pkg::CFG_W-1:0]       cfg_data
);

	logic [7:0]  start_marker_q;
	logic [14:0] torque_limit_q;

	logic              accept;
	logic              cmd_push;
	cfp_pkg::cmd_t     cmd_in;
	cfp_pkg::cmd_t     cmd_out;
	cfp_pkg::cmd_hs_t  cmd_hs;
	logic              cmd_take;
	cfp_pkg::result_t  result;

	// config: the user writes these only while idle (not enforced here), so both ends read them directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= cfp_pkg::START_MARKER_RST;
			torque_limit_q <= cfp_pkg::TORQUE_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfp_pkg::cfg_idx_t'(cfg_index))
				cfp_pkg::CFG_START_MARKER: start_marker_q <= cfg_data[7:0];
				cfp_pkg::CFG_TORQUE_LIMIT: torque_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	cfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_marker (start_marker_q),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.cmd_valid    (cmd_push),
		.cmd          (cmd_in)
	);

	// full is conservative: any byte stalls while two frames wait
	cfp_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.hs_out  (cmd_hs),
		.rd_take (cmd_take),
		.rd_data (cmd_out)
	);

	cfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.torque_limit (torque_limit_q),
		.cmd_avail    (cmd_hs.avail),
		.cmd          (cmd_out),
		.cmd_take     (cmd_take),
		.pop          (pop),
		.empty        (empty),
		.result       (result)
	);

	assign frame_status       = result.status;
	assign torque_setting_out = result.torque;
	assign gain_setting_out   = result.gain;
	assign startup_flags_out  = result.flags;
	assign startup_seen_out   = result.seen;

endmodule

[sv/cfp_checker.sv]
// Port-level checker for the command frame parser, bound to the top level.
`include "command_frame_parser_assert.svh"

module cfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               pop,
	input logic               empty,
	input logic [1:0]         frame_status,
	input logic signed [15:0] torque_setting_out,
	input logic               startup_seen_out
);

	// a word appears on an empty queue only after an accepted byte has passed through the command queue
	`CFP_ASSERT(a_word_after_byte, ($fell(empty) |-> $past(push && !full, 2)), "word without byte")

	// once startup is reported, later words keep reporting it
	`CFP_ASSERT(a_seen_sticky, (!empty && $past(!empty && pop && startup_seen_out) |-> startup_seen_out), "startup seen dropped")

	// clamp never yields the most negative code
	`CFP_NEVER(a_torque_range, (!empty && torque_setting_out == 16'sh8000), "torque out of range")

	// a waiting word holds until popped
	`CFP_ASSERT(a_word_holds, (!empty && !pop |=> !empty && $stable(frame_status) && $stable(torque_setting_out)), "word changed while waiting")

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (.*);

[bench/cfp_frame_checker.sv]
// Checker for the command frame parser: predicts each result word and compares it.
`timescale 1ns / 100ps

module cfp_frame_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [7:0]                      rx_byte,
	input  logic                            pop,
	input  logic                            empty,
	input  logic [1:0]                      frame_status,
	input  logic signed [15:0]              torque_setting_out,
	input  logic [7:0]                      gain_setting_out,
	input  logic [15:0]                     startup_flags_out,
	input  logic                            startup_seen_out,
	input  logic                            cfg_write,
	input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfp_pkg::CFG_W-1:0]       cfg_data,
	output int                              mismatch_count,
	output int                              words_outstanding
);
	import cfp_pkg::*;

	result_t predicted_words[$];

	logic [7:0]         marker;
	logic [14:0]        limit;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   flen;
	logic [7:0]         run_xor;
	logic [7:0]         frame_store[FRAME_DEPTH];
	logic signed [15:0] torque;
	logic [7:0]         gain;
	logic [15:0]        flags;
	logic               seen;

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		mismatch_count++;
		$display("MISMATCH %s: expected %h, got %h at %0t ns", what, want, got, $time);
	endtask

	// Advance the parser model by one byte; queue a word when a frame closes.
	task automatic parse_byte(input logic [7:0] b);
		result_t w;
		int t;
		int lim;
		if (pos == 0) begin
			if (b == marker) begin
				frame_store[0] = b;
				run_xor = b;
				flen = '0;
				pos = 1;
			end
		end else if (pos == 1) begin
			frame_store[1] = b;
			case (b)
				TYPE_TORQUE:  flen = LEN_TORQUE;
				TYPE_CONTROL: flen = LEN_CONTROL;
				default:      flen = '0;
			endcase
			if (flen == 0) begin
				pos = 0;
				run_xor = '0;
			end else begin
				run_xor ^= b;
				pos = 2;
			end
		end else if (int'(pos) + 1 < int'(flen) && int'(pos) + 1 < FRAME_DEPTH) begin
			frame_store[pos[2:0]] = b;
			run_xor ^= b;
			pos = pos + 1'b1;
		end else begin
			// check byte
			if (int'(pos) < FRAME_DEPTH)
				frame_store[pos[2:0]] = b;
			if (b != run_xor || flen == 0) begin
				w.status = ST_BADSUM;
			end else if (frame_store[1] == TYPE_TORQUE) begin
				t = $signed({frame_store[4], frame_store[3]});
				lim = int'(limit);
				if (t > lim)
					t = lim;
				else if (t < -lim)
					t = -lim;
				torque = 16'(t);
				gain = frame_store[5];
				w.status = ST_TORQUE;
			end else if (frame_store[3] == CMD_STARTUP) begin
				flags = {frame_store[5], frame_store[4]};
				seen = 1'b1;
				w.status = ST_STARTUP;
			end else begin
				w.status = ST_OTHER;
			end
			pos = 0;
			flen = '0;
			run_xor = '0;
			w.torque = torque;
			w.gain = gain;
			w.flags = flags;
			w.seen = seen;
			predicted_words.push_back(w);
		end
	endtask

	task automatic check_word();
		result_t want;
		if (predicted_words.size() == 0) begin
			report_mismatch("word with none expected, status", '0, 16'(frame_status));
		end else begin
			want = predicted_words.pop_front();
			if (frame_status !== want.status)
				report_mismatch("frame_status", 16'(want.status), 16'(frame_status));
			if (torque_setting_out !== want.torque)
				report_mismatch("torque_setting_out", want.torque, torque_setting_out);
			if (gain_setting_out !== want.gain)
				report_mismatch("gain_setting_out", 16'(want.gain), 16'(gain_setting_out));
			if (startup_flags_out !== want.flags)
				report_mismatch("startup_flags_out", want.flags, startup_flags_out);
			if (startup_seen_out !== want.seen)
				report_mismatch("startup_seen_out", 16'(want.seen), 16'(startup_seen_out));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker = START_MARKER_RST;
			limit = TORQUE_LIMIT_RST;
			pos = '0;
			flen = '0;
			run_xor = '0;
			foreach (frame_store[k])
				frame_store[k] = '0;
			torque = '0;
			gain = GAIN_RST;
			flags = '0;
			seen = 1'b0;
			predicted_words.delete();
			words_outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_MARKER: marker = cfg_data[7:0];
					CFG_TORQUE_LIMIT: limit = cfg_data[14:0];
					default: ;
				endcase
			end
			if (push && !full)
				parse_byte(rx_byte);
			if (pop && !empty)
				check_word();
			words_outstanding <= predicted_words.size();
		end
	end

endmodule

[bench/tb_command_frame_parser.sv]
// Testbench top for the command frame parser: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_command_frame_parser;
	import cfp_pkg::*;

	// Watchdog: far above the slowest legal run (every byte sent with the
	// longest sender gap, plus result stalls and back pressure).
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            rx_byte = '0;
	logic                  pop = 1'b0;
	logic                  empty;
	logic [1:0]            frame_status;
	logic signed [15:0]    torque_setting_out;
	logic [7:0]            gain_setting_out;
	logic [15:0]           startup_flags_out;
	logic                  startup_seen_out;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_MARKER;
	logic [CFG_W-1:0]      cfg_data = '0;

	int mismatch_count;
	int words_outstanding;

	// Sender side state
	logic [7:0] cur_marker;
	int         cur_limit;
	logic [7:0] frame_buf[8];
	int         frame_bytes_sent = 0;
	int         tx_gap_pct = 5;    // chance per byte of a sender gap
	int         rx_stall_pct = 3;  // chance per cycle of a receiver stall
	int         stall_left = 0;
	int         cycles = 0;

	always #4 clk = ~clk;

	command_frame_parser DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.rx_byte            (rx_byte),
		.pop                (pop),
		.empty              (empty),
		.frame_status       (frame_status),
		.torque_setting_out (torque_setting_out),
		.gain_setting_out   (gain_setting_out),
		.startup_flags_out  (startup_flags_out),
		.startup_seen_out   (startup_seen_out),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	cfp_frame_checker frame_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.rx_byte            (rx_byte),
		.pop                (pop),
		.empty              (empty),
		.frame_status       (frame_status),
		.torque_setting_out (torque_setting_out),
		.gain_setting_out   (gain_setting_out),
		.startup_flags_out  (startup_flags_out),
		.startup_seen_out   (startup_seen_out),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatch_count     (mismatch_count),
		.words_outstanding  (words_outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d words outstanding",
				cycles, words_outstanding);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: pop stays high except in random stall bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
			stall_left <= $urandom_range(0, 18);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Send one byte; returns at the edge where it was taken. push is left
	// high so back-to-back bytes need no extra assignment.
	task automatic send_byte(input logic [7:0] b);
		if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		frame_bytes_sent++;
	endtask

	// Padding bytes sometimes carry the marker, which must read as plain data.
	function automatic logic [7:0] pad_byte();
		return ($urandom_range(0, 3) == 0) ? cur_marker : 8'($urandom);
	endfunction

	// frame_buf[1 .. len-2] must be filled; marker and check byte are added here.
	// keep < len cuts the frame short.
	task automatic send_frame(input int len, input bit bad_sum, input int keep);
		logic [7:0] sum;
		frame_buf[0] = cur_marker;
		sum = '0;
		for (int i = 0; i < len - 1; i++)
			sum ^= frame_buf[i];
		frame_buf[len-1] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
		for (int i = 0; i < keep; i++)
			send_byte(frame_buf[i]);
	endtask

	task automatic torque_frame(input logic [15:0] value, input logic [7:0] gain_b,
			input bit bad_sum, input int keep);
		frame_buf[1] = TYPE_TORQUE;
		frame_buf[2] = pad_byte();
		frame_buf[3] = value[7:0];
		frame_buf[4] = value[15:8];
		frame_buf[5] = gain_b;
		frame_buf[6] = pad_byte();
		send_frame(int'(LEN_TORQUE), bad_sum, keep);
	endtask

	task automatic control_frame(input logic [7:0] cmd, input logic [15:0] value,
			input bit bad_sum, input int keep);
		frame_buf[1] = TYPE_CONTROL;
		frame_buf[2] = pad_byte();
		frame_buf[3] = cmd;
		frame_buf[4] = value[7:0];
		frame_buf[5] = value[15:8];
		send_frame(int'(LEN_CONTROL), bad_sum, keep);
	endtask

	// Torque values: full range, around the clamp edges, or small.
	function automatic logic [15:0] pick_torque();
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, 65535);
			1: begin
				v = cur_limit + $urandom_range(0, 6) - 3;
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				v = $urandom_range(0, 255);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return 16'(v);
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_setting(input logic [7:0] m, input int lim);
		write_reg(CFG_START_MARKER, CFG_W'(m));
		write_reg(CFG_TORQUE_LIMIT, CFG_W'(lim));
		cur_marker = m;
		cur_limit = lim;
	endtask

	// Stop sending, wait for every predicted word, then let the pipe settle.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; the rest is line noise,
	// unknown types, bad check bytes and frames cut short.
	task automatic random_traffic(input int amount, input bit quiet);
		int stop;
		int pick;
		stop = frame_bytes_sent + amount;
		if (quiet) begin
			tx_gap_pct = 0;
			rx_stall_pct <= 0;
		end
		while (frame_bytes_sent < stop) begin
			if (!quiet && $urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: tx_gap_pct = 0;
					1: tx_gap_pct = 5;
					default: tx_gap_pct = 20;
				endcase
				case ($urandom_range(0, 2))
					0: rx_stall_pct <= 0;
					1: rx_stall_pct <= 3;
					default: rx_stall_pct <= 12;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				torque_frame(pick_torque(), 8'($urandom), $urandom_range(0, 11) == 0,
					int'(LEN_TORQUE));
			end else if (pick < 70) begin
				control_frame(($urandom_range(0, 9) < 6) ? CMD_STARTUP : 8'($urandom),
					16'($urandom), $urandom_range(0, 11) == 0, int'(LEN_CONTROL));
			end else if (pick < 80) begin
				// noise while hunting
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom));
			end else if (pick < 88) begin
				// marker followed by a random type byte
				send_byte(cur_marker);
				send_byte(8'($urandom));
			end else if (pick < 94) begin
				torque_frame(pick_torque(), 8'($urandom), 1'b0,
					$urandom_range(2, int'(LEN_TORQUE) - 1));
			end else begin
				control_frame(CMD_STARTUP, 16'($urandom), 1'b0,
					$urandom_range(2, int'(LEN_CONTROL) - 1));
			end
		end
	endtask

	initial begin
		cur_marker = START_MARKER_RST;
		cur_limit = int'(TORQUE_LIMIT_RST);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: most negative torque clamps to minus the default limit,
		// startup command, some other command, and an unknown type.
		tx_gap_pct = 0;
		torque_frame(16'h8000, 8'h00, 1'b0, int'(LEN_TORQUE));
		control_frame(CMD_STARTUP, 16'hFFFF, 1'b0, int'(LEN_CONTROL));
		control_frame(8'h00, 16'h1234, 1'b0, int'(LEN_CONTROL));
		send_byte(cur_marker);
		send_byte(8'hFF);
		random_traffic(180, 1'b0);
		drain_results();

		// Marker zero, limit zero: every torque clamps to 0. Bad check byte first.
		apply_setting(8'h00, 0);
		torque_frame(16'h7FFF, 8'hFF, 1'b1, int'(LEN_TORQUE));
		random_traffic(180, 1'b0);
		drain_results();

		// Widest limit: -32768 must come back as -32767.
		apply_setting(8'hFF, 32767);
		torque_frame(16'h8000, 8'h80, 1'b0, int'(LEN_TORQUE));
		random_traffic(180, 1'b0);
		drain_results();

		apply_setting(8'($urandom), $urandom_range(1, 32766));
		random_traffic(180, 1'b0);
		drain_results();

		// Back to defaults, and no idling on either side to the end.
		apply_setting(START_MARKER_RST, int'(TORQUE_LIMIT_RST));
		random_traffic(180, 1'b1);
		drain_results();

		if (mismatch_count == 0 && words_outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
